// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the divider.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that is also evaluated during reset.
`define ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/div192_pkg.sv =====
// Types and constants shared by the 192-by-64 divider modules.
package div192_pkg;

	localparam int WORD_W  = 64;
	localparam int NUM_W   = 3 * WORD_W;
	localparam int STEPS   = NUM_W;
	localparam int CNT_W   = $clog2(STEPS);
	localparam int TDATA_W = 4 * WORD_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_DRAIN
	} div_state_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} div_ctrl_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic start;
		logic zero_div;
		logic out_free;
	} div_stat_t;

endpackage

// ===== sv/div192_step.sv =====
// One restoring division step: shift in a numerator bit, trial subtract, select.
module div192_step (
	input  logic [div192_pkg::WORD_W-1:0] rem,
	input  logic                          num_bit,
	input  logic [div192_pkg::WORD_W-1:0] den,
	output logic [div192_pkg::WORD_W-1:0] rem_next,
	output logic                          q_bit
);
	import div192_pkg::*;

	logic [WORD_W:0]   shifted;
	logic [WORD_W+1:0] diff;

	// The shifted value is 65 bits wide; its top bit is the carry out of the remainder.
	assign shifted  = {rem, num_bit};
	assign diff     = {1'b0, shifted} - {2'b00, den};
	assign q_bit    = ~diff[WORD_W+1];
	assign rem_next = q_bit ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];

endmodule

// ===== sv/div192_seq.sv =====
// Sequencer for the divider: state machine and quotient bit counter.
module div192_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  div192_pkg::div_stat_t stat,
	output div192_pkg::div_ctrl_t ctrl,
	output logic                  in_ready
);
	import div192_pkg::*;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

	div_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.load) begin
				cnt_q <= '0;
			end else if (ctrl.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (stat.start) begin
					ctrl.load = 1'b1;
					state_d   = stat.zero_div ? ST_DRAIN : ST_BUSY;
				end
			end
			ST_BUSY: begin
				ctrl.step = 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (stat.out_free) begin
					ctrl.finish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/divider_192_by_64_core.sv =====
// Top level of the 192-by-64 unsigned restoring divider with a stream interface.
// A result enters the output register after all quotient steps; a zero divisor skips the steps.
// Only one division is in flight: no new input is accepted until its result has entered the output register,
// and the single 66-bit subtractor produces one quotient bit per cycle for all 192 numerator bits.
// Reset: arst_n clears the sequencer and the output valid flag; data registers are not reset.
module divider_192_by_64_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// s_tdata, low bit first: numerator_low[63:0], numerator_mid[63:0],
	// numerator_high[63:0], divisor[63:0]
	input  logic [div192_pkg::TDATA_W-1:0] s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// m_tdata, low bit first: quotient_low[63:0], quotient_mid[63:0],
	// quotient_high[63:0], remainder[63:0]
	output logic [div192_pkg::TDATA_W-1:0] m_tdata,
	// m_tuser: divide_by_zero[0]
	output logic                           m_tuser
);
	import div192_pkg::*;

	div_ctrl_t ctrl;
	div_stat_t stat;

	// Working registers. The numerator register shifts left once per step; the quotient
	// bit from each step enters at the bottom, so after all steps it holds the quotient.
	logic [NUM_W-1:0]  work_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] den_q;
	logic              dbz_q;

	// Output register. It holds a finished result until the sink takes it, which lets
	// the block start on the next transaction in the meantime.
	logic               out_valid_q;
	logic [TDATA_W-1:0] out_data_q;
	logic               out_dbz_q;

	logic [WORD_W-1:0] in_den;
	logic [NUM_W-1:0]  in_num;
	logic [WORD_W-1:0] rem_next;
	logic              q_bit;

	assign in_num = s_tdata[NUM_W-1:0];
	assign in_den = s_tdata[TDATA_W-1:NUM_W];

	assign stat.start    = s_tvalid & s_tready;
	assign stat.zero_div = (in_den == '0);
	assign stat.out_free = ~out_valid_q | m_tready;

	div192_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.ctrl     (ctrl),
		.in_ready (s_tready)
	);

	div192_step u_step (
		.rem      (rem_q),
		.num_bit  (work_q[NUM_W-1]),
		.den      (den_q),
		.rem_next (rem_next),
		.q_bit    (q_bit)
	);

	// A zero divisor skips the iterations: the quotient is loaded as zero and the
	// remainder takes the low numerator word directly.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			work_q <= stat.zero_div ? '0 : in_num;
			rem_q  <= stat.zero_div ? in_num[WORD_W-1:0] : '0;
			den_q  <= in_den;
			dbz_q  <= stat.zero_div;
		end else if (ctrl.step) begin
			work_q <= {work_q[NUM_W-2:0], q_bit};
			rem_q  <= rem_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			out_data_q <= {rem_q, work_q};
			out_dbz_q  <= dbz_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_dbz_q;

endmodule

// ===== sv/div192_checker.sv =====
// Port-level checker for the divider and the bind that attaches it to the top level.
`include "assert_macros.svh"

module div192_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [div192_pkg::TDATA_W-1:0] m_tdata,
	input logic                           m_tuser
);
	import div192_pkg::*;

	// A zero divisor must come back with an all-zero quotient.
	`ASSERT_CLK(a_dbz_quotient_zero, (m_tvalid && m_tuser) |-> (m_tdata[NUM_W-1:0] == '0), "divide by zero result has a nonzero quotient")

	// The divider works on one transaction at a time.
	`ASSERT_CLK(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "input accepted again right after a transaction")

	// A stalled result keeps its data.
	`ASSERT_CLK(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

	// No result is offered while reset is asserted.
	`ASSERT_ALWAYS(a_no_valid_in_reset, !arst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind divider_192_by_64_core div192_checker u_div192_checker (.*);

// ===== sim/divider_192_by_64_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the 192-by-64 stream divider, with its own division predictor.
module divider_192_by_64_core_tb;

	import div192_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 250;
	localparam int RANDOM_ITEMS  = 740;
	localparam int STEADY_ITEMS  = 40;

	// One quotient and remainder as the block returns it on the master side.
	typedef struct packed {
		logic [WORD_W-1:0] quotient_low;
		logic [WORD_W-1:0] quotient_mid;
		logic [WORD_W-1:0] quotient_high;
		logic [WORD_W-1:0] remainder;
		logic              divide_by_zero;
	} division_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [TDATA_W-1:0]   m_tdata;
	logic                 m_tuser;

	division_result_t     pending_divisions[$];
	int unsigned          mismatch_count = 0;
	int unsigned          cycle_count = 0;
	bit                   idling_on = 1'b1;

	divider_192_by_64_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The predictor divides the full 192-bit numerator with the simulator's own
	// wide arithmetic, which gives the same quotient and remainder as bit-serial
	// restoring division. A zero divisor returns a zero quotient, the low
	// numerator word as the remainder, and raises the flag.
	function automatic division_result_t predict_division(input logic [TDATA_W-1:0] operands);
		logic [NUM_W-1:0]  numerator;
		logic [NUM_W-1:0]  wide_divisor;
		logic [NUM_W-1:0]  quotient;
		logic [NUM_W-1:0]  remainder;
		division_result_t  result;
		numerator    = operands[NUM_W-1:0];
		wide_divisor = {{(NUM_W-WORD_W){1'b0}}, operands[TDATA_W-1:NUM_W]};
		if (wide_divisor == '0) begin
			result.quotient_low   = '0;
			result.quotient_mid   = '0;
			result.quotient_high  = '0;
			result.remainder      = numerator[WORD_W-1:0];
			result.divide_by_zero = 1'b1;
		end else begin
			quotient  = numerator / wide_divisor;
			remainder = numerator % wide_divisor;
			result.quotient_low   = quotient[WORD_W-1:0];
			result.quotient_mid   = quotient[2*WORD_W-1:WORD_W];
			result.quotient_high  = quotient[NUM_W-1:2*WORD_W];
			result.remainder      = remainder[WORD_W-1:0];
			result.divide_by_zero = 1'b0;
		end
		return result;
	endfunction

	task automatic compare_field(input string field_name, input logic [WORD_W-1:0] expected_value,
			input logic [WORD_W-1:0] actual_value);
		if (actual_value !== expected_value) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, field_name,
				expected_value, actual_value);
			mismatch_count++;
		end
	endtask

	// Checks each result transaction against the oldest prediction, then records
	// the prediction for any operand transaction taken at the same edge. A result
	// can never belong to an operand accepted at the same edge, so this order is safe.
	always @(posedge clk) begin : result_monitor
		division_result_t oldest;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_divisions.size() == 0) begin
					$display("%0t ns: result with no division outstanding, expected none, actual %h / %b",
						$time, m_tdata, m_tuser);
					mismatch_count++;
				end else begin
					oldest = pending_divisions.pop_front();
					compare_field("quotient_low", oldest.quotient_low, m_tdata[WORD_W-1:0]);
					compare_field("quotient_mid", oldest.quotient_mid, m_tdata[2*WORD_W-1:WORD_W]);
					compare_field("quotient_high", oldest.quotient_high, m_tdata[NUM_W-1:2*WORD_W]);
					compare_field("remainder", oldest.remainder, m_tdata[TDATA_W-1:NUM_W]);
					compare_field("divide_by_zero", {{(WORD_W-1){1'b0}}, oldest.divide_by_zero},
						{{(WORD_W-1){1'b0}}, m_tuser});
				end
			end
			if (s_tvalid && s_tready)
				pending_divisions.push_back(predict_division(s_tdata));
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// The result side stalls in random bursts while idling is on.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (idling_on && $urandom_range(0, 15) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Drives one operand transaction and returns at the edge that accepts it.
	// Valid stays high between back-to-back transactions.
	task automatic send_division(input logic [NUM_W-1:0] numerator,
			input logic [WORD_W-1:0] divisor);
		@(negedge clk);
		if (idling_on && $urandom_range(0, 2) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {divisor, numerator};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic hold_off_until_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_divisions.size() != 0) @(posedge clk);
	endtask

	function automatic logic [WORD_W-1:0] random_word();
		logic [WORD_W-1:0] word;
		word = {$urandom, $urandom};
		// Shorter operands exercise wide quotients and early subtracts.
		if ($urandom_range(0, 2) == 0)
			word = word >> $urandom_range(0, WORD_W - 1);
		return word;
	endfunction

	function automatic logic [WORD_W-1:0] random_numerator_word();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return random_word();
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] random_divisor();
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return '1;
			2:       return {1'b1, {(WORD_W-1){1'b0}}} | random_word();
			3:       return 64'd1 << $urandom_range(0, WORD_W - 1);
			default: return random_word();
		endcase
	endfunction

	// Operand extremes: zero divisors, unit and full-width divisors, numerators
	// below, equal to and twice the divisor, and divisors with the top bit
	// set so the partial remainder carries out of 64 bits.
	task automatic test_directed_cases();
		logic [WORD_W-1:0] ones;
		logic [WORD_W-1:0] top_bit;
		ones    = '1;
		top_bit = {1'b1, {(WORD_W-1){1'b0}}};
		send_division('0, '0);
		send_division('1, '0);
		send_division({64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 64'h5555_aaaa_5555_aaaa},
			'0);
		send_division('0, 64'd1);
		send_division('1, 64'd1);
		send_division('1, ones);
		send_division('1, top_bit);
		send_division('1, top_bit | 64'd1);
		send_division('1, ones - 64'd1);
		send_division({{(2*WORD_W){1'b0}}, ones}, ones);
		send_division({{(2*WORD_W){1'b0}}, ones - 64'd1}, ones);
		send_division({{(2*WORD_W-1){1'b0}}, ones, 1'b0}, ones);
		send_division({{(2*WORD_W){1'b0}}, 64'd5}, 64'd7);
		send_division({{(2*WORD_W){1'b0}}, 64'd7}, 64'd7);
		send_division({ones, {(2*WORD_W){1'b0}}}, 64'd3);
		send_division({{WORD_W{1'b0}}, ones, {WORD_W{1'b0}}}, top_bit | 64'd3);
		send_division({top_bit, {(2*WORD_W){1'b0}}}, 64'd2);
		send_division({64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa},
			64'h5555_5555_5555_5555);
		send_division('1, 64'hffff_ffff);
		send_division({{(2*WORD_W){1'b0}}, 64'd1}, ones);
	endtask

	task automatic test_random_divisions(input int count);
		int n;
		for (n = 0; n < count; n++)
			send_division({random_numerator_word(), random_numerator_word(),
				random_numerator_word()}, random_divisor());
	endtask

	// The sender stops until every outstanding result is back, then resumes.
	task automatic test_drain_pause();
		test_random_divisions(10);
		hold_off_until_drained();
		test_random_divisions(10);
		hold_off_until_drained();
	endtask

	// Closing stretch with the source always valid and the sink always ready.
	task automatic test_steady_stream(input int count);
		idling_on = 1'b0;
		test_random_divisions(count);
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_random_divisions(RANDOM_ITEMS);
		test_drain_pause();
		test_steady_stream(STEADY_ITEMS);

		hold_off_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_divisions.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
